FILE: sv/crce_pkg.sv
// ----------------------------------------------------------------------------
// crce_pkg - shared types and constants for the closed Catmull-Rom evaluator
// Field widths, fixed-point formats, operation codes and pipeline types.
// ----------------------------------------------------------------------------
package crce_pkg;

	// field widths
	localparam int COORD_W  = 32;
	localparam int PARAM_W  = 22;
	localparam int PFRAC_W  = 16;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int POINT_W  = 3 * COORD_W;

	// point table defaults
	localparam int MAX_POINTS_DEF = 64;
	localparam int MIN_POINTS     = 4;

	// segment index arithmetic: wide enough for n << (MOD_STEPS-1) and any address
	localparam int MOD_W     = 11;
	localparam int MOD_STEPS = 4;

	// weights are exact with WFRAC_W fraction bits
	localparam int WFRAC_W  = 48;
	localparam int WEIGHT_W = 54;
	localparam int SPLIT_W  = 24;
	localparam int WH_W     = WEIGHT_W - SPLIT_W;
	localparam int PH_W     = WH_W + COORD_W;
	localparam int PL_W     = SPLIT_W + 1 + COORD_W;
	localparam int SH_W     = PH_W + 2;
	localparam int SL_W     = PL_W + 2;
	localparam int HI_W     = SH_W + 1;
	localparam int RSH_W    = WFRAC_W + 1 - SPLIT_W;
	localparam int RES_W    = HI_W - RSH_W;

	localparam logic signed [WEIGHT_W-1:0] W_ONE =
		$signed(WEIGHT_W'(64'd1 << WFRAC_W));
	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(2147483647);
	localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

	// stream widths
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 6 * COORD_W;

	// items that can be in flight: six stages plus two output entries
	localparam int PIPE_SLOTS = 8;
	localparam int OUTST_W    = 4;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef enum logic {
		KIND_ACK  = 1'b0,
		KIND_EVAL = 1'b1
	} kind_t;

	typedef logic [3:0][WEIGHT_W-1:0] wquad_t;
	typedef logic [3:0][COORD_W-1:0]  pquad_t;

	typedef struct packed {
		kind_t                  kind;
		logic [OUT_TDATA_W-1:0] data;
	} res_t;

endpackage

FILE: sv/crce_ram.sv
// ----------------------------------------------------------------------------
// crce_ram - generic RAM, one write port, two registered read ports
// Read data updates only when re is high.
// ----------------------------------------------------------------------------
module crce_ram #(
	parameter int WIDTH = crce_pkg::POINT_W,
	parameter int DEPTH = crce_pkg::MAX_POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: sv/crce_blend.sv
// ----------------------------------------------------------------------------
// crce_blend - one axis: weighted sums of four points, round, saturate
// Products in s5, partial sums in s6, rounding and clamp after s6.
// ----------------------------------------------------------------------------
module crce_blend (
	input  logic                   clk,
	input  logic                   en,
	input  crce_pkg::wquad_t       wp,
	input  crce_pkg::wquad_t       wd,
	input  crce_pkg::pquad_t       pts,
	output logic [crce_pkg::COORD_W-1:0] pos,
	output logic [crce_pkg::COORD_W-1:0] deriv
);
	import crce_pkg::*;

	wquad_t                  wsel [2];
	logic signed [PH_W-1:0]  ph_s5 [2][4];
	logic signed [PL_W-1:0]  pl_s5 [2][4];
	logic signed [SH_W-1:0]  sh_sum [2];
	logic signed [SL_W-1:0]  sl_sum [2];
	logic signed [SH_W-1:0]  sh_s6 [2];
	logic signed [SL_W-1:0]  sl_s6 [2];
	logic signed [HI_W-1:0]  hi [2];
	logic signed [RES_W-1:0] rs [2];
	logic signed [RES_W-1:0] sat [2];

	assign wsel[0] = wp;
	assign wsel[1] = wd;

	// split each weight at SPLIT_W: high part signed, low part unsigned
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				for (int i = 0; i < 4; i++) begin
					ph_s5[k][i] <= $signed(wsel[k][i][WEIGHT_W-1:SPLIT_W]) * $signed(pts[i]);
					pl_s5[k][i] <= $signed({1'b0, wsel[k][i][SPLIT_W-1:0]}) * $signed(pts[i]);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			sh_sum[k] = '0;
			sl_sum[k] = '0;
			for (int i = 0; i < 4; i++) begin
				sh_sum[k] = sh_sum[k] + SH_W'(ph_s5[k][i]);
				sl_sum[k] = sl_sum[k] + SL_W'(pl_s5[k][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s6 <= sh_sum;
			sl_s6 <= sl_sum;
		end
	end

	// halve and round half up: (sum + 2^48) >>> 49, done on the split form
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			hi[k] = HI_W'(sh_s6[k]) + HI_W'(sl_s6[k] >>> SPLIT_W)
				+ $signed(HI_W'(1) << SPLIT_W);
			rs[k] = RES_W'(hi[k] >>> RSH_W);
			if (rs[k] > SAT_HI) begin
				sat[k] = SAT_HI;
			end else if (rs[k] < SAT_LO) begin
				sat[k] = SAT_LO;
			end else begin
				sat[k] = rs[k];
			end
		end
	end

	assign pos   = sat[0][COORD_W-1:0];
	assign deriv = sat[1][COORD_W-1:0];

endmodule

FILE: sv/catmull_rom_closed_eval_unit.sv
// ----------------------------------------------------------------------------
// catmull_rom_closed_eval_unit - closed uniform Catmull-Rom curve evaluator
// Stores control points and returns position and tangent per parameter item.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------
//  s_*      | in  | s_tvalid/tready  | tuser op, tdata index/x/y/z/param
//  m_*      | out | m_tvalid/tready  | tuser result kind, tdata pos x/y/z, deriv
//  cfg_*    | in  | cfg_we           | point count (7 bits)
//
//  Throughput: one item per clock while s_tready is high. An accepted item
//  loads s1, then passes through s2..s6 and the output register to m_tvalid.
//  Every stage takes a new item each cycle unless the pipeline stalls; the
//  point store is two copies with two read ports each, so the four neighbor
//  points come out in the same cycle.
//  Reset: clears all valid bits and sets the point count to 4. The point
//  store is not cleared; a slot reads as garbage until it is written.
//  Stalls: results queue in a two-entry output buffer. Only when both entries
//  are full does s_tready drop, and then the whole pipeline holds in place.
//
module catmull_rom_closed_eval_unit #(
	parameter int MAX_POINTS = crce_pkg::MAX_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config: point count
	input  logic                             cfg_we,
	input  logic [crce_pkg::CNT_W-1:0]       cfg_wdata,
	// input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [0:0]                       s_tuser,  // op
	// point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
	// curve_param[123:102], zero fill [127:124]
	input  logic [crce_pkg::IN_TDATA_W-1:0]  s_tdata,
	// result items
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [0:0]                       m_tuser,  // result_kind
	// pos_x[31:0], pos_y[63:32], pos_z[95:64],
	// deriv_x[127:96], deriv_y[159:128], deriv_z[191:160]
	output logic [crce_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import crce_pkg::*;

	localparam int ADDR_W = $clog2(MAX_POINTS);

	// global advance: every stage moves when the output buffer has room
	logic en;

	// effective point count, clamped at write time
	logic [CNT_W-1:0] n_q;

	// s1: registered input item
	logic               v_s1;
	op_t                op_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [POINT_W-1:0] pt_s1;
	logic [PARAM_W-1:0] par_s1;

	// s1 -> s2: segment and neighbor indexes, u^2
	logic [MOD_W-1:0]     rem, nw, seg, i0, i1, i2, i3, seg1, seg2;
	logic                 wr_ok;
	logic [PFRAC_W-1:0]   u_c;
	logic [2*PFRAC_W-1:0] u2_c;

	// s2: memory access stage
	logic                 v_s2;
	op_t                  op_s2;
	logic                 wok_s2;
	logic [ADDR_W-1:0]    waddr_s2;
	logic [POINT_W-1:0]   wdata_s2;
	logic [ADDR_W-1:0]    addr_s2 [4];
	logic [PFRAC_W-1:0]   u_s2;
	logic [2*PFRAC_W-1:0] u2_s2;
	logic                 ram_we, ram_re;

	// s3: points from memory, powers of t
	logic                 v_s3;
	op_t                  op_s3;
	logic [PFRAC_W-1:0]   u_s3;
	logic [2*PFRAC_W-1:0] u2_s3;
	logic [3*PFRAC_W-1:0] u3_s3;
	logic [POINT_W-1:0]   rd [4];

	// s3 -> s4: basis weights
	logic signed [WEIGHT_W-1:0] e1, e2, e3;
	wquad_t                     wp_c, wd_c;

	// s4: weights and per-axis points
	logic   v_s4;
	op_t    op_s4;
	wquad_t wp_s4, wd_s4;
	pquad_t px_s4, py_s4, pz_s4;

	// s5, s6: products and sums live in the blend units
	logic v_s5, v_s6;
	op_t  op_s5, op_s6;
	logic [COORD_W-1:0] pos_x, pos_y, pos_z, der_x, der_y, der_z;

	// output buffer: head entry drives the port, second entry catches a stall
	res_t res_c;
	res_t head_q, skid_q;
	logic head_v_q, skid_v_q;
	logic pop, push;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CNT_W'(MIN_POINTS);
		end else if (cfg_we) begin
			if (cfg_wdata < CNT_W'(MIN_POINTS)) begin
				n_q <= CNT_W'(MIN_POINTS);
			end else if (MOD_W'(cfg_wdata) > MOD_W'(MAX_POINTS)) begin
				n_q <= CNT_W'(MAX_POINTS);
			end else begin
				n_q <= cfg_wdata;
			end
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------- s1: input register ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op_t'(s_tuser[0]);
			idx_s1 <= s_tdata[IDX_W-1:0];
			pt_s1  <= s_tdata[IDX_W +: POINT_W];
			par_s1 <= s_tdata[IDX_W+POINT_W +: PARAM_W];
		end
	end

	// ---------------- s1 -> s2: segment select ----------------
	// integer part mod n by conditional subtracts of n*8, n*4, n*2, n
	always_comb begin
		nw  = MOD_W'(n_q);
		rem = MOD_W'(par_s1[PARAM_W-1:PFRAC_W]);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (rem >= (nw << k)) begin
				rem = rem - (nw << k);
			end
		end
		seg  = rem;
		seg1 = seg + MOD_W'(1);
		seg2 = seg + MOD_W'(2);
		i0   = (seg == '0) ? nw - MOD_W'(1) : seg - MOD_W'(1);
		i1   = seg;
		i2   = (seg1 == nw) ? '0 : seg1;
		i3   = (seg2 >= nw) ? seg2 - nw : seg2;
		// a slot beyond the store is dropped but still acknowledged
		wr_ok = MOD_W'(idx_s1) < MOD_W'(MAX_POINTS);
		u_c   = par_s1[PFRAC_W-1:0];
		u2_c  = u_c * u_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2      <= op_s1;
			wok_s2     <= wr_ok;
			waddr_s2   <= ADDR_W'(idx_s1);
			wdata_s2   <= pt_s1;
			addr_s2[0] <= i0[ADDR_W-1:0];
			addr_s2[1] <= i1[ADDR_W-1:0];
			addr_s2[2] <= i2[ADDR_W-1:0];
			addr_s2[3] <= i3[ADDR_W-1:0];
			u_s2       <= u_c;
			u2_s2      <= u2_c;
		end
	end

	// ---------------- s2: point store ----------------
	// writes and reads both happen in s2, so items see the store in order
	assign ram_we = en && v_s2 && (op_s2 == OP_WRITE) && wok_s2;
	assign ram_re = en && v_s2 && (op_s2 == OP_EVAL);

	crce_ram #(
		.WIDTH(POINT_W),
		.DEPTH(MAX_POINTS)
	) u_ram_lo (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr_s2),
		.wdata  (wdata_s2),
		.re     (ram_re),
		.raddr_a(addr_s2[0]),
		.raddr_b(addr_s2[1]),
		.rdata_a(rd[0]),
		.rdata_b(rd[1])
	);

	crce_ram #(
		.WIDTH(POINT_W),
		.DEPTH(MAX_POINTS)
	) u_ram_hi (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr_s2),
		.wdata  (wdata_s2),
		.re     (ram_re),
		.raddr_a(addr_s2[2]),
		.raddr_b(addr_s2[3]),
		.rdata_a(rd[2]),
		.rdata_b(rd[3])
	);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			u_s3  <= u_s2;
			u2_s3 <= u2_s2;
			u3_s3 <= (3*PFRAC_W)'(u2_s2) * (3*PFRAC_W)'(u_s2);
		end
	end

	// ---------------- s3 -> s4: basis weights, scaled by 2^48 ----------------
	always_comb begin
		e1 = $signed(WEIGHT_W'({u_s3, {(WFRAC_W-PFRAC_W){1'b0}}}));
		e2 = $signed(WEIGHT_W'({u2_s3, {(WFRAC_W-2*PFRAC_W){1'b0}}}));
		e3 = $signed(WEIGHT_W'(u3_s3));
		// position: -t3+2t2-t, 3t3-5t2+2, -3t3+4t2+t, t3-t2
		wp_c[0] = (e2 <<< 1) - e3 - e1;
		wp_c[1] = (e3 <<< 1) + e3 - (e2 <<< 2) - e2 + (W_ONE <<< 1);
		wp_c[2] = (e2 <<< 2) + e1 - (e3 <<< 1) - e3;
		wp_c[3] = e3 - e2;
		// tangent: -3t2+4t-1, 9t2-10t, -9t2+8t+1, 3t2-2t
		wd_c[0] = (e1 <<< 2) - (e2 <<< 1) - e2 - W_ONE;
		wd_c[1] = (e2 <<< 3) + e2 - (e1 <<< 3) - (e1 <<< 1);
		wd_c[2] = (e1 <<< 3) + W_ONE - (e2 <<< 3) - e2;
		wd_c[3] = (e2 <<< 1) + e2 - (e1 <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4 <= op_s3;
			wp_s4 <= wp_c;
			wd_s4 <= wd_c;
			for (int i = 0; i < 4; i++) begin
				px_s4[i] <= rd[i][0*COORD_W +: COORD_W];
				py_s4[i] <= rd[i][1*COORD_W +: COORD_W];
				pz_s4[i] <= rd[i][2*COORD_W +: COORD_W];
			end
		end
	end

	// ---------------- s4 -> s6: per-axis blend ----------------
	crce_blend u_blend_x (
		.clk  (clk),
		.en   (en),
		.wp   (wp_s4),
		.wd   (wd_s4),
		.pts  (px_s4),
		.pos  (pos_x),
		.deriv(der_x)
	);

	crce_blend u_blend_y (
		.clk  (clk),
		.en   (en),
		.wp   (wp_s4),
		.wd   (wd_s4),
		.pts  (py_s4),
		.pos  (pos_y),
		.deriv(der_y)
	);

	crce_blend u_blend_z (
		.clk  (clk),
		.en   (en),
		.wp   (wp_s4),
		.wd   (wd_s4),
		.pts  (pz_s4),
		.pos  (pos_z),
		.deriv(der_z)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s5 <= op_s4;
			op_s6 <= op_s5;
		end
	end

	// write acks carry all-zero data
	always_comb begin
		res_c.kind = (op_s6 == OP_EVAL) ? KIND_EVAL : KIND_ACK;
		res_c.data = (op_s6 == OP_EVAL)
			? {der_z, der_y, der_x, pos_z, pos_y, pos_x}
			: '0;
	end

	// ---------------- output buffer ----------------
	assign pop  = head_v_q && m_tready;
	assign push = en && v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (head_v_q && !pop) begin
			skid_v_q <= push;
		end else begin
			head_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (head_v_q && !pop) begin
			if (push) begin
				skid_q <= res_c;
			end
		end else if (push) begin
			head_q <= res_c;
		end
	end

	assign m_tvalid = head_v_q;
	assign m_tuser  = head_q.kind;
	assign m_tdata  = head_q.data;

endmodule

FILE: sv/crce_checker.sv
// ----------------------------------------------------------------------------
// crce_checker - port-level checks for the closed Catmull-Rom evaluator
// Tracks items in flight and checks the output handshake and write acks.
// ----------------------------------------------------------------------------
module crce_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [0:0]                       m_tuser,
	input logic [crce_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import crce_pkg::*;

	logic               in_acc, out_acc;
	logic [OUTST_W-1:0] outst_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (in_acc && !out_acc) begin
			outst_q <= outst_q + OUTST_W'(1);
		end else if (out_acc && !in_acc) begin
			outst_q <= outst_q - OUTST_W'(1);
		end
	end

	// no result without an item in flight
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> outst_q != '0)
		else $error("result shown with no item in flight");

	// pipeline plus output buffer never holds more than its slots
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= OUTST_W'(PIPE_SLOTS))
		else $error("more items in flight than pipeline slots");

	// input is only held back while a result waits at the output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// write acknowledgements carry zero data
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind_t'(m_tuser[0]) == KIND_ACK |-> m_tdata == '0)
		else $error("write ack with nonzero data");

	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

endmodule

bind catmull_rom_closed_eval_unit crce_checker u_crce_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tuser (m_tuser),
	.m_tdata (m_tdata)
);
